// ===== rtl/dsfp_pkg.sv =====
package dsfp_pkg;

  localparam int FRAME_BYTES = 24;
  localparam int NUM_WORDS   = 9;
  // bytes 2 .. FRAME_BYTES-2 are kept; the final byte is used as it arrives
  localparam int TAIL_DEPTH  = FRAME_BYTES - 3;
  localparam int POS_W       = $clog2(FRAME_BYTES);
  localparam int SUM_W       = 13;
  localparam int RESULT_BITS = 1 + 16 * (NUM_WORDS + 1);
  localparam int TDATA_W     = ((RESULT_BITS + 7) / 8) * 8;

  localparam logic [7:0] START_RESET = 8'd66;

endpackage

// ===== rtl/dust_sensor_frame_parser.sv =====
// A result is loaded into the output register on the clock edge that accepts
// the last byte of a frame.
// Throughput: one byte per cycle; the input stalls only while a finished
// result waits on m_axis_tready.
// Reset (rst, synchronous): back to hunting, output empty, start_byte = 0x42.
module dust_sensor_frame_parser
  import dsfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [0] checksum_ok, [16:1] frame_length, then pm1_cf1, pm25_cf1, pm10_cf1,
  // pm1_atm, pm25_atm, pm10_atm, extra_word_a, extra_word_b, extra_word_c,
  // 16 bits each upward from bit 17; zero padded to the top
  output logic [TDATA_W-1:0] m_axis_tdata
);

  logic [7:0]       start_byte;
  logic             in_frame;
  logic [POS_W-1:0] byte_position;
  logic [SUM_W-1:0] running_sum;
  logic [7:0]       tail [TAIL_DEPTH];
  logic             out_valid;
  logic [TDATA_W-1:0] out_data;

  logic             accept;
  logic             take;
  logic             last;
  logic [POS_W-1:0] pos_cur;
  logic [SUM_W-1:0] sum_cur;
  logic [SUM_W-1:0] running_sum_next;
  logic [TDATA_W-1:0] result;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign take    = accept && (in_frame || (s_axis_tdata == start_byte));
  assign pos_cur = in_frame ? byte_position : '0;
  assign sum_cur = in_frame ? running_sum : '0;
  assign last    = take && (pos_cur == POS_W'(FRAME_BYTES - 1));

  always_comb begin
    if (pos_cur < POS_W'(FRAME_BYTES - 2)) begin
      running_sum_next = sum_cur + SUM_W'(s_axis_tdata);
    end else begin
      running_sum_next = sum_cur;
    end
  end

  // tail[j] holds frame byte j+2 when the last byte arrives
  always_comb begin
    result = '0;
    result[0] = ({{(16 - SUM_W){1'b0}}, sum_cur} == {tail[TAIL_DEPTH-1], s_axis_tdata});
    result[16:1] = {tail[0], tail[1]};
    for (int k = 0; k < NUM_WORDS; k++) begin
      result[17 + 16*k +: 16] = {tail[2 + 2*k], tail[3 + 2*k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte    <= START_RESET;
      in_frame      <= 1'b0;
      byte_position <= '0;
      running_sum   <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        start_byte <= cfg_wdata;
      end
      if (take) begin
        if (last) begin
          in_frame      <= 1'b0;
          byte_position <= '0;
          running_sum   <= '0;
        end else begin
          in_frame      <= 1'b1;
          byte_position <= pos_cur + 1'b1;
          running_sum   <= running_sum_next;
        end
      end
      if (last) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int j = 0; j < TAIL_DEPTH - 1; j++) begin
        tail[j] <= tail[j+1];
      end
      tail[TAIL_DEPTH-1] <= s_axis_tdata;
    end
    if (last) begin
      out_data <= result;
    end
  end

endmodule

// ===== rtl/dsfp_checker.sv =====
module dsfp_checker
  import dsfp_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               cfg_we,
  input logic [7:0]         cfg_wdata,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic [7:0]         s_axis_tdata,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata
);

  default clocking cb @(posedge clk); endclocking

  // stalled result holds
  a_out_hold: assert property (disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // skid: input is open whenever the output register can drain
  a_ready: assert property (disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("tready does not follow output register state");

  // a new result only appears after an accepted byte
  a_rise: assert property (disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result without an accepted byte");

  a_reset: assert property (rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_pad: assert property (disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[TDATA_W-1:RESULT_BITS] == '0))
    else $error("tdata padding not zero");

endmodule

bind dust_sensor_frame_parser dsfp_checker u_dsfp_checker (.*);

// ===== sim/frame_checker.sv =====
`timescale 1ns / 1ps
module frame_checker
  import dsfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [0] checksum_ok, [16:1] frame_length, nine data words from bit 17 up
  input  logic [TDATA_W-1:0] m_axis_tdata,
  output int                 fail_count,
  output int                 frames_pending,
  output logic               frame_open
);

  typedef struct packed {
    logic                    sum_ok;
    logic [15:0]             frame_length;
    logic [16*NUM_WORDS-1:0] words;
  } frame_result_t;

  string word_names [NUM_WORDS] = '{"pm1_cf1", "pm25_cf1", "pm10_cf1", "pm1_atm",
                                    "pm25_atm", "pm10_atm", "extra_word_a",
                                    "extra_word_b", "extra_word_c"};

  frame_result_t    frames_due [$];
  logic [7:0]       start_byte;
  logic             collecting;
  logic [POS_W-1:0] byte_pos;
  logic [SUM_W-1:0] byte_sum;
  logic [7:0]       frame_bytes [FRAME_BYTES];

  initial begin
    fail_count     = 0;
    frames_pending = 0;
    frame_open     = 1'b0;
  end

  function automatic logic [15:0] word_at(input int idx);
    return {frame_bytes[idx], frame_bytes[idx+1]};
  endfunction

  // parser model: hunt for the start value, collect the frame, finish on its last byte
  task automatic absorb_byte(input logic [7:0] b);
    frame_result_t r;
    if (!collecting && b != start_byte) return;
    if (!collecting) begin
      collecting = 1'b1;
      byte_pos   = '0;
      byte_sum   = '0;
    end
    frame_bytes[byte_pos] = b;
    if (byte_pos < FRAME_BYTES - 2) byte_sum = byte_sum + b;
    if (byte_pos != FRAME_BYTES - 1) begin
      byte_pos = byte_pos + 1'b1;
      return;
    end
    // sum is 13 bits, compared against the whole 16-bit trailer
    r.sum_ok       = ({3'b000, byte_sum} == word_at(FRAME_BYTES - 2));
    r.frame_length = word_at(2);
    for (int k = 0; k < NUM_WORDS; k++) r.words[16*k +: 16] = word_at(4 + 2*k);
    frames_due.push_back(r);
    collecting = 1'b0;
    byte_pos   = '0;
    byte_sum   = '0;
  endtask

  task automatic check_result(input logic [TDATA_W-1:0] d);
    frame_result_t want;
    if (frames_due.size() == 0) begin
      $error("result request with no frame pending: tdata %h", d);
      fail_count++;
      return;
    end
    want = frames_due.pop_front();
    if (d[0] !== want.sum_ok) begin
      $error("checksum_ok: expected %0d, got %0d", want.sum_ok, d[0]);
      fail_count++;
    end
    if (d[16:1] !== want.frame_length) begin
      $error("frame_length: expected %h, got %h", want.frame_length, d[16:1]);
      fail_count++;
    end
    for (int k = 0; k < NUM_WORDS; k++) begin
      if (d[17+16*k +: 16] !== want.words[16*k +: 16]) begin
        $error("%s: expected %h, got %h", word_names[k], want.words[16*k +: 16],
               d[17+16*k +: 16]);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start_byte = START_RESET;
      collecting = 1'b0;
      byte_pos   = '0;
      byte_sum   = '0;
      frames_due.delete();
    end else begin
      if (cfg_we) start_byte = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) absorb_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
    end
    frames_pending <= frames_due.size();
    frame_open     <= collecting;
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import dsfp_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [7:0]         cfg_wdata = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;

  int         fail_count;
  int         frames_pending;
  logic       frame_open;
  logic       idle_on = 1'b0;
  logic [7:0] start_val = START_RESET;
  int         bytes_sent = 0;

  dust_sensor_frame_parser u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  frame_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .fail_count     (fail_count),
    .frames_pending (frames_pending),
    .frame_open     (frame_open)
  );

  always #1 clk = ~clk;

  initial begin
    #500us;
    $display("dust_sensor_frame_parser test failed");
    $finish;
  end

  // result side: random stall bursts while idling is on
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // spoil: flip one trailer bit; saturate: byte 1 = start value, payload all ones
  task automatic send_frame(input bit spoil, input bit saturate);
    logic [7:0]  fb [FRAME_BYTES];
    logic [15:0] sum;
    logic [15:0] trailer;
    fb[0] = start_val;
    if (saturate) begin
      fb[1] = start_val;
      for (int i = 2; i < FRAME_BYTES - 2; i++) fb[i] = 8'hFF;
    end else begin
      fb[1] = $urandom_range(0, 1) ? 8'h4D : 8'($urandom_range(0, 255));
      fb[2] = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255));
      fb[3] = $urandom_range(0, 1) ? 8'd20 : 8'($urandom_range(0, 255));
      for (int i = 4; i < FRAME_BYTES - 2; i++) begin
        case ($urandom_range(0, 7))
          0:       fb[i] = start_val;  // start value as plain data
          1:       fb[i] = 8'hFF;
          2:       fb[i] = 8'h00;
          default: fb[i] = 8'($urandom_range(0, 255));
        endcase
      end
    end
    sum = '0;
    for (int i = 0; i < FRAME_BYTES - 2; i++) sum = sum + fb[i];
    trailer = spoil ? (sum ^ (16'd1 << $urandom_range(0, 15))) : sum;
    fb[FRAME_BYTES-2] = trailer[15:8];
    fb[FRAME_BYTES-1] = trailer[7:0];
    for (int i = 0; i < FRAME_BYTES; i++) send_byte(fb[i]);
  endtask

  // finish any open frame with filler, then hold off until all results are out
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (frame_open) begin
      send_byte(8'($urandom_range(0, 255)));
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    wait (frames_pending == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_start(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    start_val = v;
  endtask

  initial begin
    logic [7:0] start_list [5];
    int         phase_end;
    start_list = '{START_RESET, 8'h00, 8'hFF, 8'($urandom_range(1, 254)), START_RESET};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // stray bytes while hunting, then a frame with the start value repeated
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(1'b0, 1'b1);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        drain();
        write_start(start_list[ph]);
      end
      // start 0xFF with an all-ones payload gives the largest sum
      if (ph == 2) send_frame(1'b0, 1'b1);
      phase_end = bytes_sent + 210;
      while (bytes_sent < phase_end) begin
        idle_on = (ph < 4) && ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 9))
          0, 1: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
          2: begin
            // cut-off frame: the bytes that follow get swallowed into it
            send_byte(start_val);
            repeat ($urandom_range(1, 22)) send_byte(8'($urandom_range(0, 255)));
          end
          3, 4:    send_frame(1'b1, 1'b0);
          default: send_frame(1'b0, 1'b0);
        endcase
      end
    end

    idle_on = 1'b0;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    for (int w = 0; w < 2000 && frames_pending != 0; w++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && frames_pending == 0) begin
      $display("dust_sensor_frame_parser test passed");
    end else begin
      $display("dust_sensor_frame_parser test failed");
    end
    $finish;
  end

endmodule
